/* hw/rtl/ctr_pkg.sv */
// ----------------------------------------------------------------------------
// ctr_pkg: shared types and constants of the combined Tausworthe generator
// Holds the channel beat types, the operation codes, the seeding constants
// and the controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package ctr_pkg;

  // Operation codes carried in the op field of an input beat.
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_FRAC = 2'd2;

  // Generator geometry.
  localparam int NUM_COMP     = 5;
  localparam int COMP_W       = 64;
  localparam int HALF_W       = COMP_W / 2;
  localparam int IDX_W        = $clog2(NUM_COMP);
  localparam int FRAC_SHIFT   = 11;

  // Seeding recurrence z = A * prev + B (mod 2^64).
  localparam logic [COMP_W-1:0] MUL_A = 64'h27bb2ee687b0b0fd;
  localparam logic [COMP_W-1:0] ADD_B = 64'h891087b8e3b70cb1;

  // Warm-up advances after seeding, and the cap on fraction retries.
  localparam int WARMUP_STEPS = 10;
  localparam int WARM_W       = $clog2(WARMUP_STEPS + 1);
  localparam int FRAC_TRIES   = 64;
  localparam int TRY_W        = $clog2(FRAC_TRIES);

  // Component index of the last component in the seeding chain.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COMP - 1);

  typedef struct packed {
    logic [1:0]        op;
    logic [COMP_W-1:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              seed_done;
  } out_item_t;

  // Which 32 x 32 partial product the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_t;

  // How the accumulator takes in the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic [IDX_W-1:0] comp_idx;
    logic             comp_wr;
    logic             adv_en;
    logic             res_cap;
    logic             res_frac;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic frac_nz;
    logic out_free;
  } dp_stat_t;

  // Lower bound of each component; a seeded value below it gets it added.
  function automatic logic [COMP_W-1:0] comp_min(input logic [IDX_W-1:0] k);
    logic [COMP_W-1:0] m;
    begin
      unique case (k)
        3'd0:    m = 64'h0000_0000_0000_0002;
        3'd1:    m = 64'h0000_0000_0000_0200;
        3'd2:    m = 64'h0000_0000_0000_1000;
        3'd3:    m = 64'h0000_0000_0002_0000;
        3'd4:    m = 64'h0000_0000_0080_0000;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

  // One Tausworthe step: ((x & mask) << s3) ^ (((x << s1) ^ x) >> s2).
  function automatic logic [COMP_W-1:0] taus_step(
    input logic [COMP_W-1:0] x,
    input logic [COMP_W-1:0] mask,
    input int                s1,
    input int                s2,
    input int                s3
  );
    begin
      return ((x & mask) << s3) ^ (((x << s1) ^ x) >> s2);
    end
  endfunction

endpackage

/* hw/rtl/combined_tausworthe_rng_64.sv */
// ----------------------------------------------------------------------------
// combined_tausworthe_rng_64: five-component 64-bit Tausworthe generator
// Seeds, draws 64-bit words, and draws 53-bit fraction numerators, retried until nonzero.
//
//   Channel  Direction  Beat type   Handshake
//   in       input      in_item_t   in_valid / in_stall
//   out      output     out_item_t  out_valid / out_stall
//
// One item is in work at a time. A word draw advances the generator once,
// a fraction draw advances it until the fraction is nonzero, at most 64
// times, and an unused op leaves the state as it is. Seeding runs each
// component through the shared 32 x 32 multiplier, then the warm-up
// advances, before the hand-off to the output register.
// Reset clears the components to zero; a stalled output holds its beat
// while the next item is already accepted and worked on.
// ----------------------------------------------------------------------------
module combined_tausworthe_rng_64 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ctr_pkg::out_item_t out_data
);
  import ctr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  ctr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/ctr_datapath.sv */
// ----------------------------------------------------------------------------
// ctr_datapath: component registers, shared multiplier and output stage
// Holds the five generator components, forms the seeding chain with one
// shared 32 x 32 multiplier and an accumulator, advances the generator, and
// keeps the result in an output register that parts the two channels.
// ----------------------------------------------------------------------------
module ctr_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ctr_pkg::in_item_t  in_data,
  input  ctr_pkg::dp_cmd_t   cmd,
  output ctr_pkg::dp_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output ctr_pkg::out_item_t out_data
);
  import ctr_pkg::*;

  logic [COMP_W-1:0] comp_r [NUM_COMP];
  logic [COMP_W-1:0] adv_nxt [NUM_COMP];
  logic [COMP_W-1:0] adv_word;
  logic [COMP_W-1:0] frac_word;
  logic [COMP_W-1:0] seed_r;
  logic [COMP_W-1:0] prev;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [COMP_W-1:0] prod_r;
  logic [COMP_W-1:0] acc_r;
  logic [COMP_W-1:0] fixed;
  logic [COMP_W-1:0] res_r;
  logic              done_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Next state of every component for one generator advance.
  always_comb begin
    adv_nxt[0] = taus_step(comp_r[0], 64'hffff_ffff_ffff_fffe, 1, 53, 10);
    adv_nxt[1] = taus_step(comp_r[1], 64'hffff_ffff_ffff_fe00, 24, 50, 5);
    adv_nxt[2] = taus_step(comp_r[2], 64'hffff_ffff_ffff_f000, 3, 23, 29);
    adv_nxt[3] = taus_step(comp_r[3], 64'hffff_ffff_fffe_0000, 5, 24, 23);
    adv_nxt[4] = taus_step(comp_r[4], 64'hffff_ffff_ff80_0000, 3, 33, 8);
    adv_word   = adv_nxt[0] ^ adv_nxt[1] ^ adv_nxt[2] ^ adv_nxt[3] ^ adv_nxt[4];
    frac_word  = adv_word >> FRAC_SHIFT;
  end

  // The previous link of the seeding chain is the seed or the prior component.
  always_comb begin
    if (cmd.comp_idx == '0) begin
      prev = seed_r;
    end else begin
      prev = comp_r[cmd.comp_idx - IDX_W'(1)];
    end
  end

  // Operand selection for the partial products of A * prev (low 64 bits).
  always_comb begin
    case (cmd.mul_sel)
      MUL_LH: begin
        mul_a = MUL_A[HALF_W-1:0];
        mul_b = prev[COMP_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = MUL_A[COMP_W-1:HALF_W];
        mul_b = prev[HALF_W-1:0];
      end
      default: begin
        mul_a = MUL_A[HALF_W-1:0];
        mul_b = prev[HALF_W-1:0];
      end
    endcase
  end

  // A derived value below its minimum is raised by that minimum.
  always_comb begin
    if (acc_r < comp_min(cmd.comp_idx)) begin
      fixed = acc_r + comp_min(cmd.comp_idx);
    end else begin
      fixed = acc_r;
    end
  end

  // Multiplier, accumulator, beat capture and result register.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= COMP_W'(mul_a) * COMP_W'(mul_b);
    end
    case (cmd.acc_op)
      ACC_INIT: acc_r <= ADD_B + prod_r;
      ACC_ADD:  acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
      default:  acc_r <= acc_r;
    endcase
    if (cmd.capture) begin
      seed_r <= in_data.seed_value;
      res_r  <= '0;
      done_r <= (in_data.op == OP_SEED);
    end else if (cmd.res_cap) begin
      res_r  <= cmd.res_frac ? frac_word : adv_word;
    end
  end

  // Component registers: seeded one at a time, advanced all together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        comp_r[k] <= '0;
      end
    end else if (cmd.adv_en) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        comp_r[k] <= adv_nxt[k];
      end
    end else if (cmd.comp_wr) begin
      comp_r[cmd.comp_idx] <= fixed;
    end
  end

  // Output register: a new beat may load while the held one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r.value     <= res_r;
      out_data_r.seed_done <= done_r;
    end
  end

  assign stat.frac_nz  = |frac_word;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

/* hw/rtl/ctr_ctrl.sv */
// ----------------------------------------------------------------------------
// ctr_ctrl: operation sequencer of the combined Tausworthe generator
// Accepts one input beat at a time and steps the datapath through seeding,
// warm-up, a single draw or the fraction retry loop, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
module ctr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  output ctr_pkg::dp_cmd_t  cmd,
  input  ctr_pkg::dp_stat_t stat
);
  import ctr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_WARM,
    ST_DRAW,
    ST_FRAC,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  logic [TRY_W-1:0] try_r, try_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    warm_nxt  = warm_r;
    try_nxt   = try_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_LL;
    cmd.acc_op   = ACC_HOLD;
    cmd.comp_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_nxt    = '0;
          idx_nxt     = '0;
          try_nxt     = '0;
          case (in_op)
            OP_SEED: state_nxt = ST_SEED;
            OP_WORD: state_nxt = ST_DRAW;
            OP_FRAC: state_nxt = ST_FRAC;
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      // Five steps per component: three partial products, then write back.
      ST_SEED: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LL;
          end
          3'd1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LH;
            cmd.acc_op  = ACC_INIT;
          end
          3'd2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HL;
            cmd.acc_op  = ACC_ADD;
          end
          3'd3: begin
            cmd.acc_op = ACC_ADD;
          end
          default: begin
            cmd.comp_wr = 1'b1;
            step_nxt    = '0;
            if (idx_r == LAST_IDX) begin
              warm_nxt  = WARM_W'(WARMUP_STEPS);
              state_nxt = ST_WARM;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        endcase
      end
      ST_WARM: begin
        if (warm_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.adv_en = 1'b1;
          warm_nxt   = warm_r - WARM_W'(1);
        end
      end
      ST_DRAW: begin
        cmd.adv_en  = 1'b1;
        cmd.res_cap = 1'b1;
        state_nxt   = ST_FINISH;
      end
      // Advance until the top bits are nonzero or the tries run out.
      ST_FRAC: begin
        cmd.adv_en   = 1'b1;
        cmd.res_cap  = 1'b1;
        cmd.res_frac = 1'b1;
        if (stat.frac_nz || (try_r == TRY_W'(FRAC_TRIES - 1))) begin
          state_nxt = ST_FINISH;
        end else begin
          try_nxt = try_r + TRY_W'(1);
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
      warm_r  <= '0;
      try_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      warm_r  <= warm_nxt;
      try_r   <= try_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* tb/sv/combined_tausworthe_rng_64_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_tausworthe_rng_64_tb: self-checking bench for the Tausworthe RNG
// Mirrors the five generator components in a scoreboard, predicts every
// result beat from the accepted input beats, and compares value and
// seed_done field by field. Stimulus starts with draws from the unseeded
// state, unused op codes and seeds that push each component below its floor,
// then runs random seed and draw mixes under random sender bursts, receiver
// stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------

// Scoreboard: own copy of the generator state and the queue of expected beats.
class rng_scoreboard;
  localparam bit [63:0] SEED_MUL     = 64'h27bb2ee687b0b0fd;
  localparam bit [63:0] SEED_ADD     = 64'h891087b8e3b70cb1;
  localparam int        WARMUP_RUNS  = 10;
  localparam int        FRAC_RETRIES = 64;
  localparam int        PRINT_CAP    = 30;

  bit [63:0]          comp [5];
  ctr_pkg::out_item_t expected_draws [$];
  int unsigned        error_count;

  // Print one mismatch line (up to a cap) and count it.
  task report(string msg);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  function bit [63:0] floor_of(int k);
    case (k)
      0:       return 64'h2;
      1:       return 64'h200;
      2:       return 64'h1000;
      3:       return 64'h20000;
      default: return 64'h800000;
    endcase
  endfunction

  // One advance of all five components; returns their XOR.
  function bit [63:0] step_components();
    comp[0] = ((comp[0] & 64'hffff_ffff_ffff_fffe) << 10) ^ (((comp[0] << 1) ^ comp[0]) >> 53);
    comp[1] = ((comp[1] & 64'hffff_ffff_ffff_fe00) << 5) ^ (((comp[1] << 24) ^ comp[1]) >> 50);
    comp[2] = ((comp[2] & 64'hffff_ffff_ffff_f000) << 29) ^ (((comp[2] << 3) ^ comp[2]) >> 23);
    comp[3] = ((comp[3] & 64'hffff_ffff_fffe_0000) << 23) ^ (((comp[3] << 5) ^ comp[3]) >> 24);
    comp[4] = ((comp[4] & 64'hffff_ffff_ff80_0000) << 8) ^ (((comp[4] << 3) ^ comp[4]) >> 33);
    return comp[0] ^ comp[1] ^ comp[2] ^ comp[3] ^ comp[4];
  endfunction

  // Multiply-add seeding step; a value under the floor gets the floor added.
  function bit [63:0] mix_seed(bit [63:0] prev, bit [63:0] floor_val);
    bit [63:0] z;
    z = SEED_MUL * prev + SEED_ADD;
    if (z < floor_val) begin
      z = z + floor_val;
    end
    return z;
  endfunction

  // Apply one accepted input beat to the state and queue its result.
  function void note_request(ctr_pkg::in_item_t beat);
    ctr_pkg::out_item_t want;
    bit [63:0]          chain;
    want = '0;
    case (beat.op)
      ctr_pkg::OP_SEED: begin
        chain = beat.seed_value;
        for (int k = 0; k < 5; k++) begin
          comp[k] = mix_seed(chain, floor_of(k));
          chain   = comp[k];
        end
        repeat (WARMUP_RUNS) void'(step_components());
        want.seed_done = 1'b1;
      end
      ctr_pkg::OP_WORD: begin
        want.value = step_components();
      end
      ctr_pkg::OP_FRAC: begin
        for (int t = 0; t < FRAC_RETRIES; t++) begin
          want.value = step_components() >> 11;
          if (want.value != 0) break;
        end
      end
      default: begin
        // Unused op code: state untouched, zero result.
      end
    endcase
    expected_draws.push_back(want);
  endfunction

  // Compare one accepted result beat with the oldest expectation.
  task check_result(ctr_pkg::out_item_t got);
    ctr_pkg::out_item_t want;
    if (expected_draws.size() == 0) begin
      report($sformatf("result with nothing expected: value=%h seed_done=%b",
                       got.value, got.seed_done));
      return;
    end
    want = expected_draws.pop_front();
    if (got.value !== want.value) begin
      report($sformatf("value got %h want %h", got.value, want.value));
    end
    if (got.seed_done !== want.seed_done) begin
      report($sformatf("seed_done got %b want %b", got.seed_done, want.seed_done));
    end
  endtask

  function int pending();
    return expected_draws.size();
  endfunction
endclass

module combined_tausworthe_rng_64_tb;
  import ctr_pkg::*;

  // Op code the block does not define.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Seeding recurrence constants, used to aim seeds at chosen components.
  localparam logic [63:0] SEED_MUL = 64'h27bb2ee687b0b0fd;
  localparam logic [63:0] SEED_ADD = 64'h891087b8e3b70cb1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  rng_scoreboard sb = new();
  int unsigned   accepted_beats = 0;
  int unsigned   burst_left = 0;

  combined_tausworthe_rng_64 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Seed that makes component k come out of the multiply-add as target,
  // found by running the recurrence backward with the inverse multiplier.
  function logic [63:0] seed_hitting(int k, logic [63:0] target);
    logic [63:0] inv;
    logic [63:0] v;
    inv = SEED_MUL;
    repeat (6) inv = inv * (64'd2 - SEED_MUL * inv);
    v = target;
    for (int j = 0; j <= k; j++) begin
      v = (v - SEED_ADD) * inv;
    end
    return v;
  endfunction

  // Offer one beat and hold it until accepted; bursts end in a random gap.
  task send_beat(input logic [1:0] op, input logic [63:0] seed);
    in_item_t beat;
    int       gap;
    beat.op         = op;
    beat.seed_value = seed;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Accepted beats on both channels feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        accepted_beats++;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // Receiver stall patterns, plus one long hold-off once traffic is flowing.
  initial begin
    int span;
    int mode;
    bit held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && accepted_beats >= 400) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Reset, directed beats, random mix, then drain.
  initial begin
    int          pick;
    logic [63:0] seed;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Draws from the all-zero state, including the capped fraction retry.
    send_beat(OP_WORD, rand64());
    send_beat(OP_FRAC, rand64());
    send_beat(OP_NONE, '1);

    // Seed extremes and every op after them.
    send_beat(OP_SEED, '0);
    send_beat(OP_WORD, '1);
    send_beat(OP_FRAC, '0);
    send_beat(OP_SEED, '1);
    send_beat(OP_NONE, '0);
    send_beat(OP_WORD, rand64());

    // Each component in turn lands below its floor during seeding.
    for (int k = 0; k < 5; k++) begin
      send_beat(OP_SEED, seed_hitting(k, '0));
      send_beat(OP_WORD, rand64());
    end
    send_beat(OP_SEED, seed_hitting(4, 64'h7f_ffff));
    send_beat(OP_FRAC, rand64());

    // Random part: mostly draws, with occasional reseeds and unused ops.
    repeat (1200) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        case ($urandom_range(0, 5))
          0:       seed = '0;
          1:       seed = '1;
          2:       seed = seed_hitting($urandom_range(0, 4), 64'($urandom_range(0, 1)));
          default: seed = rand64();
        endcase
        send_beat(OP_SEED, seed);
      end else if (pick < 9) begin
        send_beat(OP_NONE, rand64());
      end else if (pick < 55) begin
        send_beat(OP_WORD, rand64());
      end else begin
        send_beat(OP_FRAC, rand64());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
